// File: hdl/char_lcd_tick_sequencer_defines.svh
// assertion helpers used by the sequencer
`ifndef CHAR_LCD_TICK_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_TICK_SEQUENCER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CLTS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("clts: same-cycle check failed");

// next-cycle implication, checked out of reset
`define CLTS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("clts: next-cycle check failed");

`endif

// File: hdl/clts_pkg.sv
package clts_pkg;

    typedef logic [1:0] mode_t;
    typedef logic [1:0] status_t;
    typedef logic [7:0] lcd_byte_t;

    // input item kinds
    localparam mode_t MODE_TICK  = 2'd0;
    localparam mode_t MODE_LOAD  = 2'd1;
    localparam mode_t MODE_WRITE = 2'd2;
    localparam mode_t MODE_CLEAR = 2'd3;

    // request check result
    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_BAD_LINE = 2'd1;
    localparam status_t STATUS_BAD_COL  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_FOUR_BIT    = 3'd0;
    localparam logic [2:0] CFG_FUNC_SET    = 3'd1;
    localparam logic [2:0] CFG_DISP_CTRL   = 3'd2;
    localparam logic [2:0] CFG_POWER_TICKS = 3'd3;
    localparam logic [2:0] CFG_COL_COUNT   = 3'd4;

    // configuration reset values
    localparam lcd_byte_t  RST_FUNC_SET    = 8'h38;
    localparam lcd_byte_t  RST_DISP_CTRL   = 8'h0C;
    localparam lcd_byte_t  RST_POWER_TICKS = 8'd15;
    localparam logic [6:0] RST_COL_COUNT   = 7'd16;

    // lcd commands
    localparam lcd_byte_t CMD_CLEAR = 8'h01;
    localparam lcd_byte_t CMD_DDRAM = 8'h80;

    // ddram offset of each display line
    function automatic lcd_byte_t line_offset(input logic [1:0] line);
        lcd_byte_t off;
        case (line)
            2'd0: off = 8'h00;
            2'd1: off = 8'h40;
            2'd2: off = 8'h10;
            2'd3: off = 8'h50;
            default: off = 8'h00;
        endcase
        return off;
    endfunction

endpackage

// File: hdl/clts_ram.sv
module clts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                         aclk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: hdl/char_lcd_tick_sequencer.sv
// Character LCD pin sequencer for the HD44780 command set.
// Input channel (s_*): one beat per item; mode 0 is a tick that advances the
// pin sequence, mode 1 loads a byte into the character buffer, mode 2 posts
// a write request (line, column, length), mode 3 posts a clear request.
// Result channel (m_*): exactly one beat per input beat, carrying the pin
// levels (rs, rw, enable, data) after that item, busy, ready and the
// request check status.
// Configuration: cfg_we writes register cfg_index with cfg_wdata at once;
// write only while no beat is in flight.
// Latency: the result beat is valid the cycle after the input beat.
// Throughput: one item per cycle unless the result channel stalls. The
// character buffer is a RAM with a registered read; its address is issued
// from the next sequencer state, and a load to that same entry is forwarded.
// Reset: configuration returns to its defaults, the sequencer restarts the
// power-on wait, the pin latch is cleared; buffer contents are kept.
// Stall: while m_ready is low the result register holds and s_ready drops
// only when it is full and not being drained.
module char_lcd_tick_sequencer #(
    parameter int BUFFER_DEPTH = 32,
    parameter int LINE_COUNT   = 4
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_wdata,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [7:0] s_char_code,
    input  logic [4:0] s_char_index,
    input  logic [5:0] s_text_length,
    input  logic [2:0] s_line_number,
    input  logic [5:0] s_column_number,

    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_pin_rs,
    output logic       m_pin_rw,
    output logic       m_pin_enable,
    output logic [7:0] m_data_pins,
    output logic       m_busy_res,
    output logic       m_ready_res,
    output logic [1:0] m_status
);

    `include "char_lcd_tick_sequencer_defines.svh"

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int LW = $clog2(BUFFER_DEPTH + 1);

    // init steps
    localparam logic [2:0] IS_POWER = 3'd0;
    localparam logic [2:0] IS_FSET1 = 3'd1;
    localparam logic [2:0] IS_FSET2 = 3'd2;
    localparam logic [2:0] IS_DCTRL = 3'd3;
    localparam logic [2:0] IS_CLEAR = 3'd4;
    localparam logic [2:0] IS_END   = 3'd5;

    // write request steps
    localparam logic [1:0] WS_START = 2'd0;
    localparam logic [1:0] WS_ADDR  = 2'd1;
    localparam logic [1:0] WS_CHAR  = 2'd2;
    localparam logic [1:0] WS_DONE  = 2'd3;

    // clear request steps
    localparam logic [1:0] CS_START = 2'd0;
    localparam logic [1:0] CS_RUN   = 2'd1;
    localparam logic [1:0] CS_DONE  = 2'd2;

    // request kinds
    localparam logic [1:0] RK_WRITE = 2'd0;
    localparam logic [1:0] RK_CLEAR = 2'd1;
    localparam logic [1:0] RK_NONE  = 2'd2;

    // configuration
    logic       four_bit_reg;
    logic [7:0] func_set_reg;
    logic [7:0] disp_ctrl_reg;
    logic [7:0] power_ticks_reg;
    logic [6:0] col_count_reg;

    // sequencer state
    logic          top_phase_reg,  top_phase_next;
    logic [2:0]    init_step_reg,  init_step_next;
    logic [7:0]    power_cnt_reg,  power_cnt_next;
    logic          enable_reg,     enable_next;
    logic          hnn_reg,        hnn_next;
    logic          busy_reg,       busy_next;
    logic [1:0]    kind_reg,       kind_next;
    logic [1:0]    write_step_reg, write_step_next;
    logic [1:0]    clear_step_reg, clear_step_next;
    logic [7:0]    cursor_reg,     cursor_next;
    logic [LW-1:0] chars_left_reg, chars_left_next;
    logic [1:0]    saved_line_reg, saved_line_next;
    logic [5:0]    saved_col_reg,  saved_col_next;
    logic [LW-1:0] saved_len_reg,  saved_len_next;
    logic          rs_reg,         rs_next;
    logic [7:0]    bus_reg,        bus_next;
    logic [1:0]    status_reg,     status_next;
    logic          m_valid_reg;

    // buffer ram and forwarding
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic          fwd_hit_reg;
    logic [7:0]    fwd_data_reg;
    logic [7:0]    char_data;
    logic [LW-1:0] rd_idx_next;
    logic [LW-1:0] cur_idx;

    logic          s_fire;
    logic          can_take;
    logic          fr_active;
    logic          fr_rs;
    logic [7:0]    fr_byte;
    logic          fr_done;
    logic [3:0]    fr_nib;
    logic [7:0]    addr_byte;
    logic [6:0]    idx_ext;
    logic [6:0]    len_ext;
    logic [6:0]    len_clamp;

    assign s_fire   = s_valid && s_ready;
    assign s_ready  = !m_valid_reg || m_ready;
    assign can_take = !busy_reg && top_phase_reg;
    // e falls after the final part of a byte
    assign fr_done  = enable_reg && (!four_bit_reg || hnn_reg);

    assign idx_ext   = {2'b00, s_char_index};
    assign len_ext   = {1'b0, s_text_length};
    assign len_clamp = (len_ext > 7'(BUFFER_DEPTH)) ? 7'(BUFFER_DEPTH) : len_ext;
    assign addr_byte = clts_pkg::CMD_DDRAM + {2'b00, saved_col_reg}
                       + clts_pkg::line_offset(saved_line_reg);

    // character for the current write step, with a same-entry load forwarded
    assign cur_idx   = saved_len_reg - chars_left_reg;
    assign char_data = ({{(8-LW){1'b0}}, cur_idx} >= 8'(BUFFER_DEPTH)) ? 8'h00 :
                       fwd_hit_reg ? fwd_data_reg : ram_rdata;

    // next-state logic for one accepted beat
    always_comb begin
        top_phase_next  = top_phase_reg;
        init_step_next  = init_step_reg;
        power_cnt_next  = power_cnt_reg;
        enable_next     = enable_reg;
        hnn_next        = hnn_reg;
        busy_next       = busy_reg;
        kind_next       = kind_reg;
        write_step_next = write_step_reg;
        clear_step_next = clear_step_reg;
        cursor_next     = cursor_reg;
        chars_left_next = chars_left_reg;
        saved_line_next = saved_line_reg;
        saved_col_next  = saved_col_reg;
        saved_len_next  = saved_len_reg;
        rs_next         = rs_reg;
        bus_next        = bus_reg;
        status_next     = clts_pkg::STATUS_OK;
        ram_we          = 1'b0;
        fr_active       = 1'b0;
        fr_rs           = 1'b0;
        fr_byte         = 8'h00;
        fr_nib          = 4'h0;

        if (s_fire) begin
            case (s_mode)
                clts_pkg::MODE_TICK: begin
                    if (!top_phase_reg) begin
                        case (init_step_reg)
                            IS_POWER: begin
                                power_cnt_next = power_cnt_reg + 8'd1;
                                if (power_cnt_next == power_ticks_reg) begin
                                    init_step_next = IS_FSET1;
                                    enable_next    = 1'b0;
                                end
                            end
                            IS_FSET1: begin
                                fr_active = 1'b1;
                                fr_byte   = func_set_reg;
                                if (fr_done) begin
                                    init_step_next = four_bit_reg ? IS_FSET2 : IS_DCTRL;
                                end
                            end
                            IS_FSET2: begin
                                fr_active = 1'b1;
                                fr_byte   = func_set_reg;
                                if (fr_done) begin
                                    init_step_next = IS_DCTRL;
                                end
                            end
                            IS_DCTRL: begin
                                fr_active = 1'b1;
                                fr_byte   = disp_ctrl_reg;
                                if (fr_done) begin
                                    init_step_next = IS_CLEAR;
                                end
                            end
                            IS_CLEAR: begin
                                fr_active = 1'b1;
                                fr_byte   = clts_pkg::CMD_CLEAR;
                                if (fr_done) begin
                                    init_step_next = IS_END;
                                end
                            end
                            default: begin
                                top_phase_next = 1'b1;
                            end
                        endcase
                    end else if (busy_reg && kind_reg == RK_WRITE) begin
                        case (write_step_reg)
                            WS_START: begin
                                write_step_next = WS_ADDR;
                                enable_next     = 1'b0;
                            end
                            WS_ADDR: begin
                                cursor_next = addr_byte;
                                fr_active   = 1'b1;
                                fr_byte     = addr_byte;
                                if (fr_done) begin
                                    write_step_next = WS_CHAR;
                                end
                            end
                            WS_CHAR: begin
                                if (chars_left_reg != '0) begin
                                    fr_active = 1'b1;
                                    fr_rs     = 1'b1;
                                    fr_byte   = char_data;
                                    if (fr_done) begin
                                        chars_left_next = chars_left_reg - LW'(1);
                                    end
                                end else begin
                                    write_step_next = WS_DONE;
                                    enable_next     = 1'b0;
                                end
                            end
                            default: begin
                                busy_next = 1'b0;
                                kind_next = RK_NONE;
                            end
                        endcase
                    end else if (busy_reg && kind_reg == RK_CLEAR) begin
                        case (clear_step_reg)
                            CS_START: begin
                                clear_step_next = CS_RUN;
                                enable_next     = 1'b0;
                            end
                            CS_RUN: begin
                                fr_active = 1'b1;
                                fr_byte   = clts_pkg::CMD_CLEAR;
                                if (fr_done) begin
                                    clear_step_next = CS_DONE;
                                end
                            end
                            default: begin
                                busy_next = 1'b0;
                                kind_next = RK_NONE;
                            end
                        endcase
                    end
                end
                clts_pkg::MODE_LOAD: begin
                    ram_we = (idx_ext < 7'(BUFFER_DEPTH));
                end
                clts_pkg::MODE_WRITE: begin
                    if ({1'b0, s_line_number} >= 4'(LINE_COUNT)) begin
                        status_next = clts_pkg::STATUS_BAD_LINE;
                    end else if ({1'b0, s_column_number} >= col_count_reg) begin
                        status_next = clts_pkg::STATUS_BAD_COL;
                    end else if (can_take) begin
                        saved_line_next = s_line_number[1:0];
                        saved_col_next  = s_column_number;
                        saved_len_next  = len_clamp[LW-1:0];
                        chars_left_next = len_clamp[LW-1:0];
                        busy_next       = 1'b1;
                        kind_next       = RK_WRITE;
                        write_step_next = WS_START;
                    end
                end
                default: begin
                    if (can_take) begin
                        busy_next       = 1'b1;
                        kind_next       = RK_CLEAR;
                        clear_step_next = CS_START;
                    end
                end
            endcase
        end

        // byte framing: raise e with the byte (or nibble) on the bus, then drop e
        if (fr_active) begin
            if (!enable_reg) begin
                rs_next     = fr_rs;
                enable_next = 1'b1;
                if (four_bit_reg) begin
                    fr_nib   = hnn_reg ? fr_byte[7:4] : fr_byte[3:0];
                    bus_next = {fr_nib, 4'h0};
                    hnn_next = !hnn_reg;
                end else begin
                    bus_next = fr_byte;
                end
            end else begin
                enable_next = 1'b0;
            end
        end
    end

    // buffer read is issued from the state the next beat will see
    assign rd_idx_next = saved_len_next - chars_left_next;
    assign ram_raddr   = rd_idx_next[AW-1:0];
    assign ram_waddr   = idx_ext[AW-1:0];

    clts_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_text_buf (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (s_char_code),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // forward a load that hits the entry being read this cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else begin
            fwd_hit_reg <= ram_we && (ram_waddr == ram_raddr);
        end
        fwd_data_reg <= s_char_code;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            four_bit_reg    <= 1'b0;
            func_set_reg    <= clts_pkg::RST_FUNC_SET;
            disp_ctrl_reg   <= clts_pkg::RST_DISP_CTRL;
            power_ticks_reg <= clts_pkg::RST_POWER_TICKS;
            col_count_reg   <= clts_pkg::RST_COL_COUNT;
        end else if (cfg_we) begin
            case (cfg_index)
                clts_pkg::CFG_FOUR_BIT:    four_bit_reg    <= cfg_wdata[0];
                clts_pkg::CFG_FUNC_SET:    func_set_reg    <= cfg_wdata;
                clts_pkg::CFG_DISP_CTRL:   disp_ctrl_reg   <= cfg_wdata;
                clts_pkg::CFG_POWER_TICKS: power_ticks_reg <= cfg_wdata;
                clts_pkg::CFG_COL_COUNT:   col_count_reg   <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // sequencer and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_phase_reg  <= 1'b0;
            init_step_reg  <= IS_POWER;
            power_cnt_reg  <= 8'd0;
            enable_reg     <= 1'b0;
            hnn_reg        <= 1'b1;
            busy_reg       <= 1'b0;
            kind_reg       <= RK_NONE;
            write_step_reg <= WS_START;
            clear_step_reg <= CS_START;
            cursor_reg     <= 8'd0;
            chars_left_reg <= '0;
            saved_line_reg <= 2'd0;
            saved_col_reg  <= 6'd0;
            saved_len_reg  <= '0;
            rs_reg         <= 1'b0;
            bus_reg        <= 8'd0;
            status_reg     <= clts_pkg::STATUS_OK;
            m_valid_reg    <= 1'b0;
        end else begin
            if (s_fire) begin
                top_phase_reg  <= top_phase_next;
                init_step_reg  <= init_step_next;
                power_cnt_reg  <= power_cnt_next;
                enable_reg     <= enable_next;
                hnn_reg        <= hnn_next;
                busy_reg       <= busy_next;
                kind_reg       <= kind_next;
                write_step_reg <= write_step_next;
                clear_step_reg <= clear_step_next;
                cursor_reg     <= cursor_next;
                chars_left_reg <= chars_left_next;
                saved_line_reg <= saved_line_next;
                saved_col_reg  <= saved_col_next;
                saved_len_reg  <= saved_len_next;
                rs_reg         <= rs_next;
                bus_reg        <= bus_next;
                status_reg     <= status_next;
            end
            if (s_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result beat
    assign m_valid      = m_valid_reg;
    assign m_pin_rs     = rs_reg;
    assign m_pin_rw     = 1'b0;
    assign m_pin_enable = enable_reg;
    assign m_data_pins  = bus_reg;
    assign m_busy_res   = busy_reg;
    assign m_ready_res  = top_phase_reg;
    assign m_status     = status_reg;

    // checks
    `CLTS_ASSERT_NOW(a_busy_after_init, aclk, aresetn, busy_reg, top_phase_reg)
    `CLTS_ASSERT_NOW(a_busy_has_kind, aclk, aresetn, busy_reg, kind_reg != RK_NONE)
    `CLTS_ASSERT_NOW(a_no_strobe_in_wait, aclk, aresetn, enable_reg, top_phase_reg || init_step_reg != IS_POWER)
    `CLTS_ASSERT_NOW(a_count_in_length, aclk, aresetn, 1'b1, chars_left_reg <= saved_len_reg)
    `CLTS_ASSERT_NEXT(a_byte_mode_nibble, aclk, aresetn, aresetn && s_fire && !four_bit_reg, $stable(hnn_reg))

endmodule
